>>> hdl/cbm_pkg.sv
// Package of shared types and constants for the cartridge bank mapper.
`default_nettype none

package cbm_pkg;

    // Width used for ROM offset arithmetic before the result is cut to the output.
    localparam int ROM_CALC_W = 24;
    localparam int PHYS_W     = 22;

    typedef enum logic [2:0] {
        TGT_NONE   = 3'd0,
        TGT_ROM    = 3'd1,
        TGT_WRAM   = 3'd2,
        TGT_SRAM   = 3'd3,
        TGT_CHR    = 3'd4,
        TGT_NT     = 3'd5,
        TGT_SPEECH = 3'd6,
        TGT_DISK   = 3'd7
    } t_target;

    typedef enum logic [1:0] {
        BOARD_ORIGINAL = 2'd0,
        BOARD_GENERIC  = 2'd1,
        BOARD_KARAOKE  = 2'd2,
        BOARD_COMPUTER = 2'd3
    } t_board;

    typedef enum logic [1:0] {
        CFG_BOARD_MODE    = 2'd0,
        CFG_ROM_BANK_BITS = 2'd1,
        CFG_FIXED_MIRROR  = 2'd2
    } t_cfg_idx;

    // Access kinds: bit 0 marks a write, bit 1 a PPU access.
    localparam logic [1:0] KIND_CPU_RD = 2'd0;
    localparam logic [1:0] KIND_CPU_WR = 2'd1;
    localparam logic [1:0] KIND_PPU_RD = 2'd2;
    localparam logic [1:0] KIND_PPU_WR = 2'd3;

    localparam logic [15:0] ADDR_LEGACY_REG = 16'hB000;
    localparam logic [15:0] ADDR_BANK_SEL   = 16'h5000;
    localparam logic [15:0] ADDR_MODE_REG   = 16'h5200;
    localparam logic [15:0] ADDR_SPEECH     = 16'h5300;
    localparam logic [12:0] ADDR_DISK_WR_HI = 13'h0AA0;  // $5500-$5507 >> 3
    localparam logic [12:0] ADDR_DISK_RD_HI = 13'h0AC0;  // $5600-$5607 >> 3

    typedef struct packed {
        t_board      board_mode;
        logic [3:0]  rom_bank_bits;
        logic        fixed_mirror;
        logic [7:0]  legacy_bank;
        logic [7:0]  bank_select;
        logic [2:0]  mode_bits;
        logic [7:0]  single_reg;
        logic        chr_page_latch;
    } t_bank_state;

    typedef struct packed {
        logic        legacy_we;
        logic        bank_we;
        logic        mode_we;
        logic        single_we;
        logic        latch_we;
        logic        latch_val;
        logic [7:0]  data;
    } t_state_upd;

    typedef struct packed {
        t_target              target;
        logic [PHYS_W-1:0]    phys;
        logic                 we;
        logic                 a10;
    } t_result;

endpackage

`default_nettype wire

>>> hdl/cbm_decode.sv
// Combinational decode of one bus access against the current banking state.
`default_nettype none

module cbm_decode #(
    parameter int ROM_ADDR_BITS    = 22,
    parameter int SECOND_RAM_BYTES = 131072,
    parameter int WORK_RAM_BYTES   = 8192,
    parameter int CHR_RAM_BYTES    = 65536
) (
    input  wire logic [1:0]          i_kind,
    input  wire logic [15:0]         i_address,
    input  wire logic [7:0]          i_data,
    input  wire cbm_pkg::t_bank_state i_state,
    output cbm_pkg::t_result         o_result,
    output cbm_pkg::t_state_upd      o_upd
);
    import cbm_pkg::*;

    localparam logic [3:0]  ROM_LIM    = 4'(ROM_ADDR_BITS - 14);
    localparam int          SRAM_STEPS = 131072 / SECOND_RAM_BYTES;
    localparam int          CHR_STEPS  = 65536 / CHR_RAM_BYTES;
    localparam logic [12:0] WRAM_MASK  = 13'(WORK_RAM_BYTES - 1);

    // Wrap by comparing the operand against every multiple of the size side by side;
    // the largest multiple that fits is taken off. The operands stay below 128K and 64K.
    function automatic logic [16:0] sram_wrap(input logic [16:0] x);
        logic [17:0] v;
        v = {1'b0, x};
        for (int k = 1; k <= SRAM_STEPS; k++) begin
            if ({1'b0, x} >= 18'(k * SECOND_RAM_BYTES)) begin
                v = {1'b0, x} - 18'(k * SECOND_RAM_BYTES);
            end
        end
        return v[16:0];
    endfunction

    function automatic logic [15:0] chr_wrap(input logic [15:0] x);
        logic [16:0] v;
        v = {1'b0, x};
        for (int k = 1; k <= CHR_STEPS; k++) begin
            if ({1'b0, x} >= 17'(k * CHR_RAM_BYTES)) begin
                v = {1'b0, x} - 17'(k * CHR_RAM_BYTES);
            end
        end
        return v[15:0];
    endfunction

    logic                  wr;
    logic [3:0]            bank_bits;
    logic [4:0]            mask_shift;
    logic [ROM_CALC_W-1:0] rom_mask;
    logic [9:0]            last_bank;
    logic [9:0]            legacy_rom_bank;
    logic                  horiz;
    logic                  latch_en;
    logic                  hi_ram;
    logic                  hi_wide;
    logic                  hi_low_half;
    logic                  hi_is_sram;
    logic [16:0]           hi_sram_raw;
    logic [ROM_CALC_W-1:0] hi_rom_raw;
    logic [PHYS_W-1:0]     hi_phys;
    logic [13:0]           pa;
    logic [15:0]           chr_raw;
    logic                  nt_a10;

    always_comb begin
        wr          = i_kind[0];
        bank_bits   = (i_state.rom_bank_bits > ROM_LIM) ? ROM_LIM : i_state.rom_bank_bits;
        mask_shift  = 5'd14 + {1'b0, bank_bits};
        rom_mask    = (ROM_CALC_W'(1) << mask_shift) - ROM_CALC_W'(1);
        last_bank   = rom_mask[ROM_CALC_W-1:14];
        legacy_rom_bank = i_address[14] ? last_bank : {8'd0, i_state.legacy_bank[7:6]};

        unique case (i_state.board_mode)
            BOARD_ORIGINAL: horiz = i_state.fixed_mirror;
            BOARD_KARAOKE:  horiz = i_state.single_reg[6];
            default:        horiz = i_state.mode_bits[0];
        endcase
        latch_en = (i_state.board_mode == BOARD_KARAOKE) ? (i_state.single_reg[7:6] != 2'd0)
                                                         : i_state.mode_bits[1];

        // Upper CPU window in the generic and computer modes.
        hi_ram      = i_state.bank_select[7];
        hi_wide     = i_state.mode_bits[2];
        hi_low_half = !i_address[14];
        hi_is_sram  = hi_ram && (hi_wide || hi_low_half);
        hi_sram_raw = hi_wide ? {i_state.bank_select[1:0], i_address[14:0]}
                              : {i_state.bank_select[2:0], i_address[13:0]};
        if (!hi_ram && hi_wide) begin
            hi_rom_raw = {1'b0, i_state.bank_select, i_address[14:0]};
        end else if (!hi_ram && hi_low_half) begin
            hi_rom_raw = {2'b0, i_state.bank_select, i_address[13:0]};
        end else begin
            hi_rom_raw = {10'd0, i_address[13:0]};
        end
        if (hi_is_sram) begin
            hi_phys = PHYS_W'(sram_wrap(hi_sram_raw));
        end else begin
            hi_phys = PHYS_W'(hi_rom_raw & rom_mask);
        end

        pa     = i_address[13:0];
        nt_a10 = horiz ? pa[11] : pa[10];
        chr_raw = {3'd0, pa[12:0]};

        o_result        = '0;
        o_result.target = TGT_NONE;
        o_upd           = '0;
        o_upd.data      = i_data;

        if (!i_kind[1]) begin
            priority if (i_state.board_mode == BOARD_ORIGINAL) begin
                if (!wr && i_address[15]) begin
                    o_result.target = TGT_ROM;
                    o_result.phys   = PHYS_W'({legacy_rom_bank, i_address[13:0]} & rom_mask);
                end else if (wr && i_address == ADDR_LEGACY_REG) begin
                    o_upd.legacy_we = 1'b1;
                end
            end else if (wr && i_address == ADDR_BANK_SEL) begin
                o_upd.bank_we  = 1'b1;
                o_upd.latch_we = 1'b1;
            end else if (wr && i_address == ADDR_MODE_REG) begin
                o_upd.mode_we  = 1'b1;
                o_upd.latch_we = 1'b1;
            end else if (i_address == ADDR_SPEECH) begin
                o_result.target = TGT_SPEECH;
                o_result.we     = wr;
            end else if (i_state.board_mode == BOARD_COMPUTER && wr
                         && i_address[15:3] == ADDR_DISK_WR_HI) begin
                o_result.target = TGT_DISK;
                o_result.phys   = PHYS_W'(i_address[2:0]);
                o_result.we     = 1'b1;
            end else if (i_state.board_mode == BOARD_COMPUTER && !wr
                         && i_address[15:3] == ADDR_DISK_RD_HI) begin
                o_result.target = TGT_DISK;
                o_result.phys   = PHYS_W'(i_address[2:0]);
            end else if (i_address[15:13] == 3'b011) begin
                o_result.target = TGT_WRAM;
                o_result.phys   = PHYS_W'(i_address[12:0] & WRAM_MASK);
                o_result.we     = wr;
            end else if (i_address[15]) begin
                if (i_state.board_mode == BOARD_KARAOKE) begin
                    if (wr) begin
                        o_upd.single_we = 1'b1;
                        o_upd.latch_we  = 1'b1;
                    end else begin
                        o_result.target = TGT_ROM;
                        o_result.phys   = PHYS_W'({4'd0, i_state.single_reg[4:0],
                                                   i_address[14:0]} & rom_mask);
                    end
                end else if (!wr) begin
                    o_result.target = hi_is_sram ? TGT_SRAM : TGT_ROM;
                    o_result.phys   = hi_phys;
                end else begin
                    if (i_state.board_mode == BOARD_COMPUTER && hi_is_sram) begin
                        o_result.target = TGT_SRAM;
                        o_result.phys   = hi_phys;
                        o_result.we     = 1'b1;
                    end
                    o_upd.latch_we = 1'b1;
                end
            end else begin
                o_result.target = TGT_NONE;
            end
        end else begin
            if (!pa[13]) begin
                o_result.target = TGT_CHR;
                o_result.we     = wr;
                if (i_state.board_mode == BOARD_ORIGINAL) begin
                    if (pa[12]) begin
                        chr_raw = {i_state.legacy_bank[3:0], pa[11:0]};
                    end
                end else if (!wr && !pa[12] && latch_en) begin
                    chr_raw        = {3'd0, i_state.chr_page_latch, pa[11:0]};
                    o_upd.latch_we = 1'b1;
                end
                o_result.phys = PHYS_W'(chr_wrap(chr_raw));
            end else if (pa[13:8] != 6'h3F) begin
                o_result.target = TGT_NT;
                o_result.we     = wr;
                o_result.a10    = nt_a10;
                o_result.phys   = PHYS_W'({nt_a10, pa[9:0]});
                if (!wr && i_state.board_mode != BOARD_ORIGINAL && !pa[12] && latch_en) begin
                    o_upd.latch_we  = 1'b1;
                    o_upd.latch_val = nt_a10;
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/cbm_regs.sv
// Configuration and banking registers of the cartridge bank mapper.
`default_nettype none

module cbm_regs (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [1:0]           i_cfg_index,
    input  wire logic [3:0]           i_cfg_data,
    input  wire logic                 i_commit,
    input  wire cbm_pkg::t_state_upd  i_upd,
    output cbm_pkg::t_bank_state      o_state
);
    import cbm_pkg::*;

    // Original board with eight ROM banks, vertical mirroring and every banking register clear.
    localparam t_bank_state STATE_RESET = '{
        board_mode:     BOARD_ORIGINAL,
        rom_bank_bits:  4'd3,
        fixed_mirror:   1'b0,
        legacy_bank:    8'd0,
        bank_select:    8'd0,
        mode_bits:      3'd0,
        single_reg:     8'd0,
        chr_page_latch: 1'b0
    };

    t_bank_state r_state;
    t_bank_state n_state;

    always_comb begin
        n_state = r_state;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BOARD_MODE:    n_state.board_mode    = t_board'(i_cfg_data[1:0]);
                CFG_ROM_BANK_BITS: n_state.rom_bank_bits = i_cfg_data;
                CFG_FIXED_MIRROR:  n_state.fixed_mirror  = i_cfg_data[0];
                default:           n_state.fixed_mirror  = r_state.fixed_mirror;
            endcase
        end
        if (i_commit) begin
            if (i_upd.legacy_we) begin
                n_state.legacy_bank = i_upd.data;
            end
            if (i_upd.bank_we) begin
                n_state.bank_select = i_upd.data;
            end
            if (i_upd.mode_we) begin
                n_state.mode_bits = i_upd.data[2:0];
            end
            if (i_upd.single_we) begin
                n_state.single_reg = i_upd.data;
            end
            if (i_upd.latch_we) begin
                n_state.chr_page_latch = i_upd.latch_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;

endmodule

`default_nettype wire

>>> hdl/cartridge_bank_mapper_unit.sv
// Top level of the cartridge bank mapper: input register, decode and result register.
// An accepted word goes from the input register through the decode to the result register.
// Throughput: one word per cycle; the input register and the result register each move
// whenever the stage after them is empty or is being drained, so both sides stream freely.
// The rate is set by the single decode pass between the two registers.
// Reset (synchronous, active low) empties both stages and clears every banking register.
`default_nettype none

module cartridge_bank_mapper_unit #(
    parameter int ROM_ADDR_BITS    = 22,
    parameter int SECOND_RAM_BYTES = 131072,
    parameter int WORK_RAM_BYTES   = 8192,
    parameter int CHR_RAM_BYTES    = 65536
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write port.
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [3:0]  i_cfg_data,
    // Bus access words.
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_kind,
    input  wire logic [15:0] i_address,
    input  wire logic [7:0]  i_data,
    // Decoded result words.
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_target,
    output logic [21:0]      o_phys_address,
    output logic             o_write_enable,
    output logic             o_ciram_a10
);
    import cbm_pkg::*;

    // Input register stage.
    logic        r_in_valid;
    logic        n_in_valid;
    logic [1:0]  r_in_kind;
    logic [15:0] r_in_address;
    logic [7:0]  r_in_data;

    // Result register stage.
    logic        r_out_valid;
    logic        n_out_valid;
    t_result     r_out;

    logic        in_take;
    logic        advance;

    t_bank_state bank_state;
    t_result     dec_result;
    t_state_upd  dec_upd;

    // A word in the input register moves on when the result register is free
    // or is being emptied this cycle; the banking state is updated at that
    // same moment, so each access sees every earlier access's effect.
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;
    assign in_take = i_valid && o_ready;

    cbm_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_commit    (advance),
        .i_upd       (dec_upd),
        .o_state     (bank_state)
    );

    cbm_decode #(
        .ROM_ADDR_BITS    (ROM_ADDR_BITS),
        .SECOND_RAM_BYTES (SECOND_RAM_BYTES),
        .WORK_RAM_BYTES   (WORK_RAM_BYTES),
        .CHR_RAM_BYTES    (CHR_RAM_BYTES)
    ) u_decode (
        .i_kind    (r_in_kind),
        .i_address (r_in_address),
        .i_data    (r_in_data),
        .i_state   (bank_state),
        .o_result  (dec_result),
        .o_upd     (dec_upd)
    );

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_take) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end

        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_kind    <= i_kind;
            r_in_address <= i_address;
            r_in_data    <= i_data;
        end
        if (advance) begin
            r_out <= dec_result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_target       = r_out.target;
    assign o_phys_address = r_out.phys;
    assign o_write_enable = r_out.we;
    assign o_ciram_a10    = r_out.a10;

    // An access that reaches nothing carries no offset and no write.
    a_none_is_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_target == TGT_NONE) |-> (o_phys_address == '0 && !o_write_enable))
        else $error("unmapped access carries an offset or a write");

    // The nametable page bit is only driven for nametable accesses.
    a_a10_only_nt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_target != TGT_NT) |-> !o_ciram_a10)
        else $error("nametable page bit set outside a nametable access");

    // Offsets stay inside the memories whose size is fixed at build time.
    a_wram_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_target == TGT_WRAM) |-> (32'(o_phys_address) < WORK_RAM_BYTES))
        else $error("work RAM offset out of range");

    a_chr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_target == TGT_CHR) |-> (32'(o_phys_address) < CHR_RAM_BYTES))
        else $error("CHR RAM offset out of range");

    // A word that cannot move on because the result side stalls stays in the input register.
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_ready) |=> (r_in_valid && $stable(r_in_address)))
        else $error("stalled access lost from the input register");

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the cartridge bank mapper: random bus traffic against a predictor.
`default_nettype none

module tb_top;

    import cbm_pkg::*;

    // Board build of the unit under test; the predictor uses the same sizes.
    localparam int unsigned ROM_ADDR_BITS    = 22;
    localparam int unsigned SECOND_RAM_BYTES = 131072;
    localparam int unsigned WORK_RAM_BYTES   = 8192;
    localparam int unsigned CHR_RAM_BYTES    = 65536;

    // Idle wait after the last result, so that the pipeline settles.
    localparam int DRAIN_CYCLES  = 4;
    localparam int CYCLE_LIMIT   = 800000;
    localparam int PHASE_WORDS   = 240;
    localparam int HOLD_CYCLES   = 120;
    localparam int HOLD_SPACING  = 600;
    localparam int REPORT_LINES  = 200;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] addr;
        logic [7:0]  data;
    } t_bus_word;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [3:0]  i_cfg_data  = '0;
    logic        i_valid     = 1'b0;
    logic [1:0]  i_kind      = '0;
    logic [15:0] i_address   = '0;
    logic [7:0]  i_data      = '0;
    logic        i_ready     = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [2:0]  o_target;
    logic [21:0] o_phys_address;
    logic        o_write_enable;
    logic        o_ciram_a10;

    cartridge_bank_mapper_unit #(
        .ROM_ADDR_BITS    (ROM_ADDR_BITS),
        .SECOND_RAM_BYTES (SECOND_RAM_BYTES),
        .WORK_RAM_BYTES   (WORK_RAM_BYTES),
        .CHR_RAM_BYTES    (CHR_RAM_BYTES)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_kind         (i_kind),
        .i_address      (i_address),
        .i_data         (i_data),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_target       (o_target),
        .o_phys_address (o_phys_address),
        .o_write_enable (o_write_enable),
        .o_ciram_a10    (o_ciram_a10)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor. The shadow copies below track the configuration and the
    // banking registers of the unit; they advance once for every word that
    // the unit accepts, in acceptance order.
    // ------------------------------------------------------------------
    t_board     cfg_board        = BOARD_ORIGINAL;
    logic [3:0] cfg_bank_bits    = 4'd3;
    logic       cfg_fixed_mirror = 1'b0;

    logic [7:0] sh_legacy_bank = '0;
    logic [7:0] sh_bank_select = '0;
    logic [2:0] sh_mode_bits   = '0;
    logic [7:0] sh_single_reg  = '0;
    logic       sh_chr_latch   = 1'b0;

    // ROM offsets wrap to the ROM size; sizes beyond the address space saturate.
    function automatic logic [31:0] rom_window_mask();
        int unsigned bits;
        bits = 32'(cfg_bank_bits);
        if (bits > ROM_ADDR_BITS - 14) bits = ROM_ADDR_BITS - 14;
        return (32'd1 << (14 + bits)) - 32'd1;
    endfunction

    function automatic logic mirror_horizontal();
        case (cfg_board)
            BOARD_ORIGINAL: return cfg_fixed_mirror;
            BOARD_KARAOKE:  return sh_single_reg[6];
            default:        return sh_mode_bits[0];
        endcase
    endfunction

    function automatic logic latch_enabled();
        if (cfg_board == BOARD_KARAOKE) return sh_single_reg[7:6] != 2'b00;
        return sh_mode_bits[1];
    endfunction

    // CPU window $8000-$FFFF on the generic and computer boards.
    task automatic map_upper_window(input logic [15:0] a, output t_target tgt,
                                    output logic [31:0] ofs);
        logic [31:0] mask;
        logic [31:0] bank;
        mask = rom_window_mask();
        bank = {24'd0, sh_bank_select};
        if (sh_bank_select[7]) begin
            if (sh_mode_bits[2]) begin
                tgt = TGT_SRAM;
                ofs = (({30'd0, sh_bank_select[1:0]} << 15) | 32'(a[14:0]))
                      % SECOND_RAM_BYTES;
            end else if (!a[14]) begin
                tgt = TGT_SRAM;
                ofs = (({29'd0, sh_bank_select[2:0]} << 14) | 32'(a[13:0]))
                      % SECOND_RAM_BYTES;
            end else begin
                tgt = TGT_ROM;
                ofs = {18'd0, a[13:0]} & mask;
            end
        end else begin
            tgt = TGT_ROM;
            if (sh_mode_bits[2])
                ofs = ((bank << 15) | 32'(a[14:0])) & mask;
            else if (!a[14])
                ofs = ((bank << 14) | 32'(a[13:0])) & mask;
            else
                ofs = {18'd0, a[13:0]} & mask;
        end
    endtask

    // Works out the decode of one bus access and applies its register side effects.
    task automatic decode_access(input logic [1:0] kind, input logic [15:0] addr,
                                 input logic [7:0] data, output t_result res);
        logic        wr;
        logic [31:0] ofs;
        logic [31:0] mask;
        logic [31:0] bank;
        logic [13:0] pa;
        t_target     upper_tgt;
        logic [31:0] upper_ofs;
        wr         = (kind == KIND_CPU_WR) || (kind == KIND_PPU_WR);
        res.target = TGT_NONE;
        res.we     = 1'b0;
        res.a10    = 1'b0;
        ofs        = '0;
        mask       = rom_window_mask();
        if (kind == KIND_CPU_RD || kind == KIND_CPU_WR) begin
            if (cfg_board == BOARD_ORIGINAL) begin
                // Lower 16K from bits 7-6 of the legacy register, upper 16K fixed to the last bank.
                if (!wr && addr[15]) begin
                    bank = !addr[14] ? {30'd0, sh_legacy_bank[7:6]} : (mask >> 14);
                    res.target = TGT_ROM;
                    ofs = ((bank << 14) | 32'(addr[13:0])) & mask;
                end else if (wr && addr == ADDR_LEGACY_REG) begin
                    sh_legacy_bank = data;
                end
            end else if (wr && addr == ADDR_BANK_SEL) begin
                sh_bank_select = data;
                sh_chr_latch   = 1'b0;
            end else if (wr && addr == ADDR_MODE_REG) begin
                sh_mode_bits = data[2:0];
                sh_chr_latch = 1'b0;
            end else if (addr == ADDR_SPEECH) begin
                res.target = TGT_SPEECH;
                res.we     = wr;
            end else if (cfg_board == BOARD_COMPUTER && wr && addr[15:3] == ADDR_DISK_WR_HI) begin
                res.target = TGT_DISK;
                ofs        = 32'(addr[2:0]);
                res.we     = 1'b1;
            end else if (cfg_board == BOARD_COMPUTER && !wr && addr[15:3] == ADDR_DISK_RD_HI) begin
                res.target = TGT_DISK;
                ofs        = 32'(addr[2:0]);
            end else if (addr[15:13] == 3'b011) begin
                res.target = TGT_WRAM;
                ofs        = 32'(addr[12:0]) % WORK_RAM_BYTES;
                res.we     = wr;
            end else if (addr[15]) begin
                if (cfg_board == BOARD_KARAOKE) begin
                    if (wr) begin
                        sh_single_reg = data;
                        sh_chr_latch  = 1'b0;
                    end else begin
                        res.target = TGT_ROM;
                        ofs = (({27'd0, sh_single_reg[4:0]} << 15) | 32'(addr[14:0])) & mask;
                    end
                end else begin
                    map_upper_window(addr, upper_tgt, upper_ofs);
                    if (!wr) begin
                        res.target = upper_tgt;
                        ofs        = upper_ofs;
                    end else begin
                        // Only the computer board may write the second RAM.
                        if (cfg_board == BOARD_COMPUTER && upper_tgt == TGT_SRAM) begin
                            res.target = TGT_SRAM;
                            ofs        = upper_ofs;
                            res.we     = 1'b1;
                        end
                        sh_chr_latch = 1'b0;
                    end
                end
            end
        end else begin
            pa = addr[13:0];
            if (pa < 14'h2000) begin
                res.target = TGT_CHR;
                res.we     = wr;
                if (cfg_board == BOARD_ORIGINAL) begin
                    if (!pa[12]) ofs = 32'(pa);
                    else         ofs = 32'({sh_legacy_bank[3:0], pa[11:0]});
                end else if (!wr && !pa[12] && latch_enabled()) begin
                    // Background fetch: the latch supplies CHR A12 once, then clears.
                    ofs          = 32'({sh_chr_latch, pa[11:0]});
                    sh_chr_latch = 1'b0;
                end else begin
                    ofs = 32'(pa[12:0]);
                end
                ofs = ofs % CHR_RAM_BYTES;
            end else if (pa < 14'h3F00) begin
                res.target = TGT_NT;
                res.we     = wr;
                res.a10    = mirror_horizontal() ? pa[11] : pa[10];
                ofs        = 32'({res.a10, pa[9:0]});
                if (!wr && cfg_board != BOARD_ORIGINAL && pa[13:12] == 2'b10 && latch_enabled())
                    sh_chr_latch = res.a10;
            end
        end
        res.phys = ofs[21:0];
    endtask

    // ------------------------------------------------------------------
    // Shared bookkeeping.
    // ------------------------------------------------------------------
    t_bus_word pending_words[$];
    t_result   expected_decodes[$];
    int        words_queued   = 0;
    int        words_accepted = 0;
    int        words_checked  = 0;
    int        mismatch_count = 0;
    int        cycle_count    = 0;

    task automatic report_mismatch(input string what);
        if (mismatch_count < REPORT_LINES)
            $display("MISMATCH cycle %0d word %0d: %s", cycle_count, words_checked, what);
        mismatch_count++;
    endtask

    // Idle lengths: mostly none or short, a few long, and now and then a calm
    // stretch of words with no idling at all.
    task automatic pick_idle(inout int calm, output int gap);
        int roll;
        roll = $urandom_range(0, 99);
        if (calm > 0) begin
            calm--;
            gap = 0;
        end else if (roll < 3) begin
            calm = $urandom_range(20, 80);
            gap  = 0;
        end else if (roll < 55) begin
            gap = 0;
        end else if (roll < 90) begin
            gap = $urandom_range(1, 3);
        end else begin
            gap = $urandom_range(6, 40);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: offers queued words, holds each one steady until accepted,
    // and runs the predictor at the edge of acceptance.
    // ------------------------------------------------------------------
    int        send_gap  = 0;
    int        send_calm = 0;
    t_bus_word next_word;
    t_result   prediction;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                decode_access(i_kind, i_address, i_data, prediction);
                expected_decodes.push_back(prediction);
                words_accepted <= words_accepted + 1;
            end
            // The slot is free once nothing is offered or the offer is being taken.
            if (!i_valid || o_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    next_word = pending_words.pop_front();
                    i_valid   <= 1'b1;
                    i_kind    <= next_word.kind;
                    i_address <= next_word.addr;
                    i_data    <= next_word.data;
                    pick_idle(send_calm, send_gap);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Long hold-off of the result side, counted here in cycles. The driver
    // keeps offering meanwhile, so the unit fills and drops o_ready.
    // ------------------------------------------------------------------
    logic hold_active  = 1'b0;
    int   hold_left    = 0;
    int   next_hold_at = 150;

    always @(posedge i_clk) begin
        if (hold_active) begin
            if (hold_left <= 1) hold_active <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (i_rst_n && words_accepted >= next_hold_at) begin
            hold_active  <= 1'b1;
            hold_left    <= HOLD_CYCLES;
            next_hold_at <= next_hold_at + HOLD_SPACING;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: takes result words, checks them against the oldest
    // prediction and stalls at random between them.
    // ------------------------------------------------------------------
    int      recv_stall = 0;
    int      recv_calm  = 0;
    t_result due;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_decodes.size() == 0) begin
                    report_mismatch("result word with no access waiting for it");
                end else begin
                    due = expected_decodes.pop_front();
                    if (o_target !== due.target)
                        report_mismatch($sformatf("target %0d, predicted %0d",
                                                  o_target, due.target));
                    if (o_phys_address !== due.phys)
                        report_mismatch($sformatf("phys_address %06h, predicted %06h",
                                                  o_phys_address, due.phys));
                    if (o_write_enable !== due.we)
                        report_mismatch($sformatf("write_enable %0b, predicted %0b",
                                                  o_write_enable, due.we));
                    if (o_ciram_a10 !== due.a10)
                        report_mismatch($sformatf("ciram_a10 %0b, predicted %0b",
                                                  o_ciram_a10, due.a10));
                end
                words_checked <= words_checked + 1;
                pick_idle(recv_calm, recv_stall);
            end
            if (hold_active) begin
                i_ready <= 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------
    task automatic push_word(input logic [1:0] kind, input logic [15:0] addr,
                             input logic [7:0] data);
        pending_words.push_back('{kind: kind, addr: addr, data: data});
        words_queued++;
    endtask

    // Waits until every queued word has come back as a result and the pipeline is empty.
    task automatic wait_drained();
        while (pending_words.size() != 0 || words_checked != words_queued)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Configuration is only touched while the unit is idle.
    task automatic apply_settings(input t_board board, input logic [3:0] bank_bits,
                                  input logic mirror);
        wait_drained();
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_BOARD_MODE;
        i_cfg_data  <= {2'b00, board};
        cfg_board = board;
        @(posedge i_clk);
        i_cfg_index <= CFG_ROM_BANK_BITS;
        i_cfg_data  <= bank_bits;
        cfg_bank_bits = bank_bits;
        @(posedge i_clk);
        i_cfg_index <= CFG_FIXED_MIRROR;
        i_cfg_data  <= {3'b000, mirror};
        cfg_fixed_mirror = mirror;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // One random transaction: most of the traffic is register programming
    // followed by accesses, and nametable fetches followed by pattern fetches,
    // so that banking and the background latch are exercised; the rest is noise.
    task automatic queue_random_traffic();
        int          pick;
        int          fetches;
        logic [31:0] r;
        logic [15:0] addr;
        logic [1:0]  cpu_kind;
        logic [1:0]  ppu_kind;
        pick     = $urandom_range(0, 99);
        r        = $urandom;
        cpu_kind = r[31] ? KIND_CPU_WR : KIND_CPU_RD;
        ppu_kind = r[30] ? KIND_PPU_WR : KIND_PPU_RD;
        if (pick < 14) begin
            case (r[29:28])
                2'd0:    addr = ADDR_BANK_SEL;
                2'd1:    addr = ADDR_MODE_REG;
                2'd2:    addr = ADDR_LEGACY_REG;
                default: addr = {1'b1, r[14:0]};
            endcase
            push_word(KIND_CPU_WR, addr, r[23:16]);
        end else if (pick < 34) begin
            push_word(cpu_kind, {1'b1, r[14:0]}, r[23:16]);
        end else if (pick < 44) begin
            case (r[29:27])
                3'd0, 3'd1: addr = ADDR_SPEECH;
                3'd2, 3'd3: addr = {ADDR_DISK_WR_HI, r[2:0]};
                3'd4, 3'd5: addr = {ADDR_DISK_RD_HI, r[2:0]};
                3'd6:       addr = ADDR_BANK_SEL;
                default:    addr = ADDR_MODE_REG;
            endcase
            push_word(cpu_kind, addr, r[23:16]);
        end else if (pick < 53) begin
            push_word(cpu_kind, {3'b011, r[12:0]}, r[23:16]);
        end else if (pick < 60) begin
            push_word(cpu_kind, r[15:0], r[23:16]);
        end else if (pick < 82) begin
            // Nametable fetch, then one to three pattern fetches in the lower table.
            push_word(KIND_PPU_RD, {r[15:14], 2'b10, r[11:0]}, r[23:16]);
            fetches = $urandom_range(1, 3);
            repeat (fetches) begin
                r = $urandom;
                push_word(r[20] ? KIND_PPU_RD : ppu_kind, {r[15:14], 2'b00, r[11:0]},
                          r[29:22]);
            end
        end else begin
            push_word(ppu_kind, r[15:0], r[23:16]);
        end
    endtask

    task automatic run_random_phase(input t_board board, input logic [3:0] bank_bits,
                                    input logic mirror);
        int phase_start;
        apply_settings(board, bank_bits, mirror);
        phase_start = words_queued;
        while (words_queued - phase_start < PHASE_WORDS)
            queue_random_traffic();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Original board with the largest ROM and horizontal mirroring:
        // legacy register at its extreme, both ROM halves at their edges,
        // both CHR pages, a nametable write, the palette and unmapped space.
        apply_settings(BOARD_ORIGINAL, 4'd8, 1'b1);
        push_word(KIND_CPU_WR, ADDR_LEGACY_REG, 8'hFF);
        push_word(KIND_CPU_RD, 16'h8000, 8'h00);
        push_word(KIND_CPU_RD, 16'hBFFF, 8'h00);
        push_word(KIND_CPU_RD, 16'hC000, 8'h00);
        push_word(KIND_CPU_RD, 16'hFFFF, 8'hFF);
        push_word(KIND_PPU_RD, 16'h0000, 8'h00);
        push_word(KIND_PPU_RD, 16'h1FFF, 8'h00);
        push_word(KIND_PPU_WR, 16'h2C00, 8'h55);
        push_word(KIND_PPU_RD, 16'h3F00, 8'h00);
        push_word(KIND_CPU_RD, 16'h0000, 8'h00);
        push_word(KIND_CPU_WR, 16'h8000, 8'hAA);

        // Computer board with the smallest ROM: 32K second RAM write, a speech port
        // read, the disk ports in both directions, work RAM, the background
        // latch being set, used once and then found clear, and bank wrapping.
        apply_settings(BOARD_COMPUTER, 4'd0, 1'b0);
        push_word(KIND_CPU_WR, ADDR_MODE_REG, 8'h06);
        push_word(KIND_CPU_WR, ADDR_BANK_SEL, 8'h83);
        push_word(KIND_CPU_WR, 16'hFFFF, 8'h5A);
        push_word(KIND_CPU_RD, 16'h8000, 8'h00);
        push_word(KIND_CPU_RD, ADDR_SPEECH, 8'h00);
        push_word(KIND_CPU_WR, {ADDR_DISK_WR_HI, 3'd7}, 8'h3C);
        push_word(KIND_CPU_RD, {ADDR_DISK_RD_HI, 3'd7}, 8'h00);
        push_word(KIND_CPU_WR, {ADDR_DISK_RD_HI, 3'd0}, 8'h11);
        push_word(KIND_CPU_WR, 16'h7FFF, 8'h00);
        push_word(KIND_PPU_RD, 16'h2400, 8'h00);
        push_word(KIND_PPU_RD, 16'h0FFF, 8'h00);
        push_word(KIND_PPU_RD, 16'h0FFF, 8'h00);
        push_word(KIND_CPU_WR, ADDR_BANK_SEL, 8'h05);
        push_word(KIND_CPU_RD, 16'hC123, 8'h00);

        // Random phases across every board mode, ROM size extremes and both mirrorings.
        run_random_phase(BOARD_GENERIC,  4'd0,  1'b1);
        run_random_phase(BOARD_KARAOKE,  4'd15, 1'b0);
        run_random_phase(BOARD_COMPUTER, 4'd8,  1'b1);
        run_random_phase(BOARD_ORIGINAL, 4'd3,  1'b0);
        run_random_phase(BOARD_GENERIC,  4'd8,  1'b0);
        run_random_phase(BOARD_COMPUTER, 4'd2,  1'b0);
        run_random_phase(BOARD_KARAOKE,  4'd1,  1'b1);
        run_random_phase(BOARD_ORIGINAL, 4'd15, 1'b1);

        wait_drained();
        if (expected_decodes.size() != 0)
            report_mismatch($sformatf("%0d predicted results never delivered",
                                      expected_decodes.size()));
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
